@@ rtl/core/udo_pkg.sv @@
// Shared types, codes and constant tables of the unison detuned oscillator.
package udo_pkg;

  localparam int unsigned CFG_IDX_W = 3;
  localparam int unsigned CFG_DATA_W = 17;
  localparam int unsigned CNT_W = 5;
  localparam int unsigned FREQ_W = 26;
  localparam int unsigned DIV_N = 64;
  localparam int unsigned DIV_D = 40;
  localparam int unsigned DIV_CNT_W = 6;

  localparam logic [CFG_IDX_W-1:0] CFG_WAVE   = 3'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_VOICES = 3'd1;
  localparam logic [CFG_IDX_W-1:0] CFG_PITCH  = 3'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_WIDTH  = 3'd3;
  localparam logic [CFG_IDX_W-1:0] CFG_GAIN   = 3'd4;
  localparam logic [CFG_IDX_W-1:0] CFG_PAN    = 3'd5;

  localparam logic [1:0] WAVE_SINE   = 2'd0;
  localparam logic [1:0] WAVE_SAW    = 2'd1;
  localparam logic [1:0] WAVE_TRI    = 2'd2;
  localparam logic [1:0] WAVE_SQUARE = 2'd3;

  localparam logic OP_ADVANCE = 1'b0;

  // 0.3 in Q0.16 and the sine polynomial coefficients
  localparam logic [14:0] DETUNE_K = 15'd19661;
  localparam logic [15:0] POLY_C1 = 16'd51472;
  localparam logic [15:0] POLY_C2 = 16'd21089;
  localparam logic [11:0] POLY_C3 = 12'd2385;

  typedef enum logic [1:0] {
    DIV_SPREAD = 2'd0,
    DIV_INC    = 2'd2
  } div_sel_e;

  typedef enum logic [23:0] {
    ST_IDLE  = 24'h000001,
    ST_START = 24'h000002,
    ST_SPR   = 24'h000004,
    ST_SPR_W = 24'h000008,
    ST_DEN1  = 24'h000010,
    ST_DEN2  = 24'h000020,
    ST_DEN3  = 24'h000040,
    ST_INC   = 24'h000080,
    ST_INC_W = 24'h000100,
    ST_STEP  = 24'h000200,
    ST_WR    = 24'h000400,
    ST_IDX   = 24'h000800,
    ST_UDIV  = 24'h001000,
    ST_P1    = 24'h004000,
    ST_P2    = 24'h008000,
    ST_P3    = 24'h010000,
    ST_P4    = 24'h020000,
    ST_ACC1  = 24'h040000,
    ST_ACC2  = 24'h080000,
    ST_NEXT  = 24'h100000,
    ST_FIN1  = 24'h200000,
    ST_FIN2  = 24'h400000,
    ST_OUT   = 24'h800000
  } state_e;

  typedef struct packed {
    logic     item_ld;
    logic     voice_inc;
    logic     div_start;
    div_sel_e div_sel;
    logic     den1;
    logic     den2;
    logic     den3;
    logic     step;
    logic     phase_we;
    logic     idx_ld;
    logic     u_ld;
    logic     p1;
    logic     p2;
    logic     p3;
    logic     p4;
    logic     acc1;
    logic     acc2;
    logic     fin1;
    logic     fin2;
    logic     out_ld;
  } cmd_t;

  typedef struct packed {
    logic op_smp;
    logic no_voices;
    logic last_voice;
    logic div_done;
    logic div_busy;
    logic out_free;
  } status_t;

  // 440 Hz times the Q16 semitone ratio
  function automatic logic [FREQ_W-1:0] freq_base(input logic [3:0] semi);
    logic [FREQ_W-1:0] f;
    case (semi)
      4'd0:    f = 26'd28835840;
      4'd1:    f = 26'd30550520;
      4'd2:    f = 26'd32367280;
      4'd3:    f = 26'd34291840;
      4'd4:    f = 26'd36330800;
      4'd5:    f = 26'd38491200;
      4'd6:    f = 26'd40780080;
      4'd7:    f = 26'd43204920;
      4'd8:    f = 26'd45774080;
      4'd9:    f = 26'd48495920;
      4'd10:   f = 26'd51379680;
      4'd11:   f = 26'd54434600;
      default: f = '0;
    endcase
    return f;
  endfunction

endpackage

@@ rtl/core/udo_div.sv @@
// Radix-2 restoring divider, one quotient bit per cycle.
module udo_div (
  input  logic                          clk_i,
  input  logic                          rst_ni,
  input  logic                          start_i,
  input  logic [udo_pkg::DIV_N-1:0]     dividend_i,
  input  logic [udo_pkg::DIV_D-1:0]     divisor_i,
  output logic [udo_pkg::DIV_N-1:0]     quot_o,
  output logic                          busy_o,
  output logic                          done_o
);

  localparam logic [udo_pkg::DIV_CNT_W-1:0] LAST = udo_pkg::DIV_CNT_W'(udo_pkg::DIV_N - 1);

  logic                          busy_q, done_q;
  logic [udo_pkg::DIV_CNT_W-1:0] cnt_q;
  logic [udo_pkg::DIV_N-1:0]     work_q;
  logic [udo_pkg::DIV_D-1:0]     rem_q, den_q;
  logic [udo_pkg::DIV_D:0]       trial, diff;
  logic                          ge;

  assign trial = {rem_q, work_q[udo_pkg::DIV_N-1]};
  assign ge    = trial >= {1'b0, den_q};
  assign diff  = trial - {1'b0, den_q};

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      busy_q <= 1'b0;
      done_q <= 1'b0;
      cnt_q  <= '0;
    end else begin
      done_q <= busy_q && (cnt_q == LAST);
      if (start_i) begin
        busy_q <= 1'b1;
        cnt_q  <= '0;
      end else if (busy_q) begin
        cnt_q <= cnt_q + 1'b1;
        if (cnt_q == LAST) busy_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (start_i) begin
      rem_q  <= '0;
      work_q <= dividend_i;
      den_q  <= divisor_i;
    end else if (busy_q) begin
      rem_q  <= ge ? diff[udo_pkg::DIV_D-1:0] : trial[udo_pkg::DIV_D-1:0];
      work_q <= {work_q[udo_pkg::DIV_N-2:0], ge};
    end
  end

  assign quot_o = work_q;
  assign busy_o = busy_q;
  assign done_o = done_q;

endmodule

@@ rtl/core/udo_ctrl.sv @@
// Sequencer that walks the voices and steps the datapath through each item.
module udo_ctrl (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             in_valid_i,
  output logic             in_ready_o,
  input  udo_pkg::status_t status_i,
  output udo_pkg::cmd_t    cmd_o
);

  udo_pkg::state_e state_q, state_d;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= udo_pkg::ST_IDLE;
    end else begin
      state_q <= state_d;
    end
  end

  assign in_ready_o = (state_q == udo_pkg::ST_IDLE);

  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    case (state_q)
      udo_pkg::ST_IDLE: begin
        if (in_valid_i) begin
          cmd_o.item_ld = 1'b1;
          state_d = udo_pkg::ST_START;
        end
      end
      udo_pkg::ST_START: begin
        if (!status_i.no_voices) state_d = udo_pkg::ST_SPR;
        else if (status_i.op_smp) state_d = udo_pkg::ST_FIN1;
        else state_d = udo_pkg::ST_IDLE;
      end
      udo_pkg::ST_SPR: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = udo_pkg::DIV_SPREAD;
        state_d = udo_pkg::ST_SPR_W;
      end
      udo_pkg::ST_SPR_W: begin
        if (status_i.div_done) state_d = status_i.op_smp ? udo_pkg::ST_IDX : udo_pkg::ST_DEN1;
      end
      udo_pkg::ST_DEN1: begin
        cmd_o.den1 = 1'b1;
        state_d = udo_pkg::ST_DEN2;
      end
      udo_pkg::ST_DEN2: begin
        cmd_o.den2 = 1'b1;
        state_d = udo_pkg::ST_DEN3;
      end
      udo_pkg::ST_DEN3: begin
        cmd_o.den3 = 1'b1;
        state_d = udo_pkg::ST_INC;
      end
      udo_pkg::ST_INC: begin
        cmd_o.div_start = 1'b1;
        cmd_o.div_sel   = udo_pkg::DIV_INC;
        state_d = udo_pkg::ST_INC_W;
      end
      udo_pkg::ST_INC_W: begin
        if (status_i.div_done) state_d = udo_pkg::ST_STEP;
      end
      udo_pkg::ST_STEP: begin
        cmd_o.step = 1'b1;
        state_d = udo_pkg::ST_WR;
      end
      udo_pkg::ST_WR: begin
        cmd_o.phase_we = 1'b1;
        state_d = udo_pkg::ST_NEXT;
      end
      udo_pkg::ST_IDX: begin
        cmd_o.idx_ld = 1'b1;
        state_d = udo_pkg::ST_UDIV;
      end
      udo_pkg::ST_UDIV: begin
        cmd_o.u_ld = 1'b1;
        state_d = udo_pkg::ST_P1;
      end
      udo_pkg::ST_P1: begin
        cmd_o.p1 = 1'b1;
        state_d = udo_pkg::ST_P2;
      end
      udo_pkg::ST_P2: begin
        cmd_o.p2 = 1'b1;
        state_d = udo_pkg::ST_P3;
      end
      udo_pkg::ST_P3: begin
        cmd_o.p3 = 1'b1;
        state_d = udo_pkg::ST_P4;
      end
      udo_pkg::ST_P4: begin
        cmd_o.p4 = 1'b1;
        state_d = udo_pkg::ST_ACC1;
      end
      udo_pkg::ST_ACC1: begin
        cmd_o.acc1 = 1'b1;
        state_d = udo_pkg::ST_ACC2;
      end
      udo_pkg::ST_ACC2: begin
        cmd_o.acc2 = 1'b1;
        state_d = udo_pkg::ST_NEXT;
      end
      udo_pkg::ST_NEXT: begin
        if (!status_i.last_voice) begin
          cmd_o.voice_inc = 1'b1;
          state_d = udo_pkg::ST_SPR;
        end else if (status_i.op_smp) begin
          state_d = udo_pkg::ST_FIN1;
        end else begin
          state_d = udo_pkg::ST_IDLE;
        end
      end
      udo_pkg::ST_FIN1: begin
        cmd_o.fin1 = 1'b1;
        state_d = udo_pkg::ST_FIN2;
      end
      udo_pkg::ST_FIN2: begin
        cmd_o.fin2 = 1'b1;
        state_d = udo_pkg::ST_OUT;
      end
      udo_pkg::ST_OUT: begin
        // hold until the output register can take the word
        if (status_i.out_free) begin
          cmd_o.out_ld = 1'b1;
          state_d = udo_pkg::ST_IDLE;
        end
      end
      default: state_d = udo_pkg::ST_IDLE;
    endcase
  end

`ifndef SYNTHESIS
  a_div_idle: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.div_start |-> !status_i.div_busy) else $error("divider restarted while busy");
  a_we_adv: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.phase_we |-> !status_i.op_smp) else $error("phase written by a sample item");
  a_out_ld: assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.out_ld |-> (status_i.out_free && status_i.op_smp))
    else $error("result loaded into a full register or for an advance");
  a_done_wait: assert property (@(posedge clk_i) disable iff (!rst_ni)
    status_i.div_done |-> (state_q == udo_pkg::ST_SPR_W || state_q == udo_pkg::ST_INC_W))
    else $error("quotient arrived outside a wait state");
`endif

endmodule

@@ rtl/core/udo_dp.sv @@
// Datapath: settings, voice phases, increment and wave arithmetic, mixer, output register.
module udo_dp #(
  parameter int unsigned MAX_VOICES       = 16,
  parameter int unsigned SAMPLE_RATE_HZ   = 48000,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  udo_pkg::cmd_t                     cmd_i,
  output udo_pkg::status_t                  status_o,
  input  logic                              cfg_we_i,
  input  logic [udo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [udo_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  input  logic                              op_i,
  input  logic [15:0]                       time_step_i,
  input  logic                              out_ready_i,
  output logic                              out_valid_o,
  output logic signed [31:0]                left_sample_o,
  output logic signed [31:0]                right_sample_o
);

  localparam int unsigned VI_W    = (MAX_VOICES > 1) ? $clog2(MAX_VOICES) : 1;
  localparam int unsigned NV_W    = $clog2(MAX_VOICES + 1);
  localparam int unsigned NC_W    = (NV_W > udo_pkg::CNT_W) ? NV_W : udo_pkg::CNT_W;
  localparam int unsigned IDX_W   = $clog2(SINE_TABLE_DEPTH);
  localparam int unsigned DEPTH_W = $clog2(SINE_TABLE_DEPTH + 1);
  localparam int unsigned RATE_W  = $clog2(SAMPLE_RATE_HZ + 1);
  localparam int unsigned ACC_W   = 32 + $clog2(MAX_VOICES + 1);
  localparam int unsigned M1_W    = ACC_W + 1;
  localparam int unsigned M2_W    = ACC_W - 4;
  localparam int unsigned INC_W   = 36;
  // reciprocal of the table depth, exact for every index below the depth
  localparam int unsigned RCP_SH  = 2 * IDX_W;
  localparam int unsigned RCP_W   = IDX_W + 18;

  localparam logic [DEPTH_W-1:0] DEPTH_C = DEPTH_W'(SINE_TABLE_DEPTH);
  localparam logic [RATE_W-1:0]  RATE_C  = RATE_W'(SAMPLE_RATE_HZ);
  localparam logic [NC_W-1:0]    NMAX_C  = NC_W'(MAX_VOICES);
  localparam logic [RCP_W-1:0]   RCP_C   = RCP_W'(((64'd1 << (RCP_SH + 16)) +
      64'(SINE_TABLE_DEPTH) - 64'd1) / 64'(SINE_TABLE_DEPTH));

  // settings
  logic [1:0]         wave_q;
  logic [4:0]         count_q;
  logic signed [6:0]  pitch_q;
  logic [15:0]        width_q, gain_q;
  logic signed [16:0] pan_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wave_q  <= udo_pkg::WAVE_SINE;
      count_q <= 5'd1;
      pitch_q <= '0;
      width_q <= '0;
      gain_q  <= 16'd32768;
      pan_q   <= '0;
    end else if (cfg_we_i) begin
      case (cfg_idx_i)
        udo_pkg::CFG_WAVE:   wave_q  <= cfg_data_i[1:0];
        udo_pkg::CFG_VOICES: count_q <= cfg_data_i[4:0];
        udo_pkg::CFG_PITCH:  pitch_q <= cfg_data_i[6:0];
        udo_pkg::CFG_WIDTH:  width_q <= cfg_data_i[15:0];
        udo_pkg::CFG_GAIN:   gain_q  <= cfg_data_i[15:0];
        udo_pkg::CFG_PAN:    pan_q   <= cfg_data_i;
        default: ;
      endcase
    end
  end

  // item and voice tracking
  logic            op_q;
  logic [15:0]     dt_q;
  logic [VI_W-1:0] voice_q;
  logic [NC_W-1:0] n_full;
  logic [NV_W-1:0] n_act, nm1;

  assign n_full = NC_W'(count_q);
  assign n_act  = (n_full > NMAX_C) ? NV_W'(MAX_VOICES) : n_full[NV_W-1:0];
  assign nm1    = n_act - NV_W'(1);

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      op_q    <= udo_pkg::OP_ADVANCE;
      voice_q <= '0;
    end else if (cmd_i.item_ld) begin
      op_q    <= op_i;
      voice_q <= '0;
    end else if (cmd_i.voice_inc) begin
      voice_q <= voice_q + 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.item_ld) dt_q <= time_step_i;
  end

  // phase memory, cleared by valid bits at reset
  logic [31:0]           phase_mem [MAX_VOICES];
  logic [MAX_VOICES-1:0] vld_q;
  logic [31:0]           mem_rd_q;
  logic                  vld_rd_q;
  logic [31:0]           phase_rd;
  logic [INC_W+15:0]     step_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.phase_we) phase_mem[voice_q] <= phase_rd + step_q[39:8];
    mem_rd_q <= phase_mem[voice_q];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      vld_q    <= '0;
      vld_rd_q <= 1'b0;
    end else begin
      if (cmd_i.phase_we) vld_q[voice_q] <= 1'b1;
      vld_rd_q <= vld_q[voice_q];
    end
  end

  assign phase_rd = vld_rd_q ? mem_rd_q : '0;

  // spread numerator 2i - (n-1)
  logic [NV_W:0]          i2;
  logic signed [NV_W+1:0] num;
  logic [NV_W+1:0]        num_abs;

  assign i2      = (NV_W + 1)'(voice_q) << 1;
  assign num     = $signed({1'b0, i2}) - $signed({2'b00, nm1});
  assign num_abs = num[NV_W+1] ? (~num + 1'b1) : num;

  // base frequency from the clamped pitch
  logic signed [6:0] pc;
  logic [6:0]        k;
  logic [3:0]        oct, semi;
  logic [udo_pkg::FREQ_W-1:0] f0;
  logic [29:0]       fq;

  always_comb begin
    if (pitch_q < -7'sd48) pc = -7'sd48;
    else if (pitch_q > 7'sd48) pc = 7'sd48;
    else pc = pitch_q;
    k = 7'(pc + 7'sd48);
    oct = '0;
    for (int j = 1; j <= 8; j++) begin
      if (k >= 7'(12 * j)) oct = oct + 4'd1;
    end
    semi = 4'(k - 7'(oct) * 7'd12);
    f0 = udo_pkg::freq_base(semi);
    if (oct >= 4'd4) fq = 30'(f0) << (oct - 4'd4);
    else fq = 30'(f0) >> (4'd4 - oct);
  end

  // divider and its operand select
  logic [udo_pkg::DIV_N-1:0] div_dividend, div_quot;
  logic [udo_pkg::DIV_D-1:0] div_divisor, den_q;
  logic                      div_busy, div_done;
  udo_pkg::div_sel_e         sel_q;
  logic [29:0]               f_q;
  logic [IDX_W-1:0]          idx_q;
  logic [IDX_W+RCP_W-1:0]    u_prod;

  always_comb begin
    case (cmd_i.div_sel)
      udo_pkg::DIV_SPREAD: begin
        div_dividend = udo_pkg::DIV_N'(num_abs) << 15;
        div_divisor  = (n_act > NV_W'(1)) ? udo_pkg::DIV_D'(nm1) : udo_pkg::DIV_D'(1);
      end
      udo_pkg::DIV_INC: begin
        div_dividend = udo_pkg::DIV_N'(f_q) << 32;
        div_divisor  = den_q;
      end
      default: begin
        div_dividend = '0;
        div_divisor  = udo_pkg::DIV_D'(1);
      end
    endcase
  end

  udo_div u_div (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .start_i    (cmd_i.div_start),
    .dividend_i (div_dividend),
    .divisor_i  (div_divisor),
    .quot_o     (div_quot),
    .busy_o     (div_busy),
    .done_o     (div_done)
  );

  logic signed [16:0] s_q;
  logic [15:0]        u_q;
  logic [INC_W-1:0]   inc_q;
  logic               num_neg_q;

  // table position scaled to 16 bits: idx * 65536 / depth
  assign u_prod = idx_q * RCP_C;

  always_ff @(posedge clk_i) begin
    if (cmd_i.div_start) begin
      sel_q     <= cmd_i.div_sel;
      num_neg_q <= num[NV_W+1];
    end
    if (cmd_i.u_ld) u_q <= u_prod[RCP_SH+15:RCP_SH];
    if (div_done) begin
      case (sel_q)
        udo_pkg::DIV_SPREAD: begin
          if (n_act <= NV_W'(1)) s_q <= '0;
          else if (num_neg_q) s_q <= -$signed(div_quot[16:0]);
          else s_q <= $signed(div_quot[16:0]);
        end
        udo_pkg::DIV_INC:  inc_q <= div_quot[INC_W-1:0];
        default: ;
      endcase
    end
  end

  // increment denominator
  logic [16:0]        s_abs17;
  logic [15:0]        s_abs;
  logic [31:0]        mag_q;
  logic [46:0]        dprod;
  logic [17:0]        denom_q;
  logic [RATE_W+17:0] den_prod;

  assign s_abs17  = s_q[16] ? 17'(-s_q) : 17'(s_q);
  assign s_abs    = s_abs17[15:0];
  assign dprod    = mag_q * udo_pkg::DETUNE_K;
  assign den_prod = RATE_C * denom_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.den1) begin
      mag_q <= s_abs * width_q;
      f_q   <= fq;
    end
    if (cmd_i.den2) begin
      denom_q <= s_q[16] ? (18'd65536 - 18'(dprod[46:30])) : (18'd65536 + 18'(dprod[46:30]));
    end
    if (cmd_i.den3) den_q <= udo_pkg::DIV_D'(den_prod);
    if (cmd_i.step) step_q <= inc_q * dt_q;
  end

  // sine polynomial
  logic [31+DEPTH_W:0] idx_prod;
  logic [1:0]          quad;
  logic [16:0]         z17;
  logic [15:0]         z_q, z2_q, t1_q, t2_q;
  logic [16:0]         v_q;
  logic [30:0]         zz;
  logic [27:0]         z2c;
  logic [31:0]         z2t, zt;

  assign idx_prod = phase_rd * DEPTH_C;
  assign quad     = u_q[15:14];
  assign z17      = quad[0] ? ((17'd16384 - 17'(u_q[13:0])) << 1) : (17'(u_q[13:0]) << 1);
  assign zz       = z17[15:0] * z17[15:0];
  assign z2c      = z2_q * udo_pkg::POLY_C3;
  assign z2t      = z2_q * t1_q;
  assign zt       = z_q * t2_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.idx_ld) idx_q <= idx_prod[32+IDX_W-1:32];
    if (cmd_i.p1) begin
      z_q  <= z17[15:0];
      z2_q <= zz[30:15];
    end
    if (cmd_i.p2) t1_q <= udo_pkg::POLY_C2 - 16'(z2c[27:15]);
    if (cmd_i.p3) t2_q <= 16'(17'(udo_pkg::POLY_C1) - z2t[31:15]);
    if (cmd_i.p4) v_q  <= zt[31:15];
  end

  // wave select and voice pan
  logic signed [15:0] x;
  logic signed [17:0] xs, dtri, w, vl, vr, s18;
  logic signed [35:0] pl_q, pr_q;
  logic signed [ACC_W-1:0] accl_q, accr_q;

  assign x   = $signed(phase_rd[31:16] ^ 16'h8000);
  assign xs  = 18'(x);
  assign s18 = 18'(s_q);

  always_comb begin
    if (xs < -18'sd16384) dtri = xs + 18'sd32768;
    else if (xs < 18'sd16384) dtri = (xs < 0) ? -xs : xs;
    else dtri = 18'sd32768 - xs;
    case (wave_q)
      udo_pkg::WAVE_SINE:   w = quad[1] ? $signed(18'(v_q)) : -$signed(18'(v_q));
      udo_pkg::WAVE_SAW:    w = xs;
      udo_pkg::WAVE_TRI:    w = (xs > 0) ? (dtri <<< 1) : ((xs < 0) ? -(dtri <<< 1) : '0);
      udo_pkg::WAVE_SQUARE: w = (xs > 0) ? 18'sd32768 : ((xs < 0) ? -18'sd32768 : '0);
      default:              w = '0;
    endcase
    vl = (s18 <= 0) ? 18'sd32768 : 18'sd32768 - s18;
    vr = (s18 >= 0) ? 18'sd32768 : 18'sd32768 + s18;
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.acc1) begin
      pl_q <= w * vl;
      pr_q <= w * vr;
    end
    if (cmd_i.item_ld) begin
      accl_q <= '0;
      accr_q <= '0;
    end else if (cmd_i.acc2) begin
      accl_q <= accl_q + ACC_W'(pl_q);
      accr_q <= accr_q + ACC_W'(pr_q);
    end
  end

  // volume and master pan
  logic signed [17:0] pan18, cl, cr;
  logic [16:0]        cl_abs, cr_abs;
  logic [ACC_W-1:0]   al_abs, ar_abs;
  logic [ACC_W+15:0]  m1l_full, m1r_full;
  logic [M1_W-1:0]    m1l_q, m1r_q;
  logic [16:0]        cla_q, cra_q;
  logic               negl_q, negr_q;
  logic [M1_W+16:0]   m2l_full, m2r_full;
  logic [M2_W-1:0]    m2l_q, m2r_q;

  assign pan18    = 18'(pan_q);
  assign cl       = (pan18 <= 0) ? 18'sd32768 : 18'sd32768 - pan18;
  assign cr       = (pan18 >= 0) ? 18'sd32768 : 18'sd32768 + pan18;
  assign cl_abs   = cl[17] ? 17'(-cl) : 17'(cl);
  assign cr_abs   = cr[17] ? 17'(-cr) : 17'(cr);
  assign al_abs   = accl_q[ACC_W-1] ? ACC_W'(-accl_q) : ACC_W'(accl_q);
  assign ar_abs   = accr_q[ACC_W-1] ? ACC_W'(-accr_q) : ACC_W'(accr_q);
  assign m1l_full = al_abs * gain_q;
  assign m1r_full = ar_abs * gain_q;
  assign m2l_full = m1l_q * cla_q;
  assign m2r_full = m1r_q * cra_q;

  always_ff @(posedge clk_i) begin
    if (cmd_i.fin1) begin
      m1l_q  <= m1l_full[ACC_W+15:15];
      m1r_q  <= m1r_full[ACC_W+15:15];
      cla_q  <= cl_abs;
      cra_q  <= cr_abs;
      negl_q <= accl_q[ACC_W-1] != cl[17];
      negr_q <= accr_q[ACC_W-1] != cr[17];
    end
    if (cmd_i.fin2) begin
      m2l_q <= m2l_full[M1_W+16:22];
      m2r_q <= m2r_full[M1_W+16:22];
    end
  end

  // saturate to 32 bits with the product's sign
  logic [63:0] ml, mr, ml_c, mr_c;
  logic [31:0] res_l, res_r;

  always_comb begin
    ml = 64'(m2l_q);
    mr = 64'(m2r_q);
    if (negl_q) ml_c = (ml > 64'h8000_0000) ? 64'h8000_0000 : ml;
    else ml_c = (ml > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : ml;
    if (negr_q) mr_c = (mr > 64'h8000_0000) ? 64'h8000_0000 : mr;
    else mr_c = (mr > 64'h7FFF_FFFF) ? 64'h7FFF_FFFF : mr;
    res_l = negl_q ? (~ml_c[31:0] + 32'd1) : ml_c[31:0];
    res_r = negr_q ? (~mr_c[31:0] + 32'd1) : mr_c[31:0];
  end

  // output register
  logic        out_valid_q;
  logic [31:0] left_q, right_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (cmd_i.out_ld) begin
      out_valid_q <= 1'b1;
    end else if (out_ready_i) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.out_ld) begin
      left_q  <= res_l;
      right_q <= res_r;
    end
  end

  assign out_valid_o    = out_valid_q;
  assign left_sample_o  = $signed(left_q);
  assign right_sample_o = $signed(right_q);

  assign status_o.op_smp     = op_q;
  assign status_o.no_voices  = (n_act == '0);
  assign status_o.last_voice = ((NV_W'(voice_q) + NV_W'(1)) == n_act);
  assign status_o.div_done   = div_done;
  assign status_o.div_busy   = div_busy;
  assign status_o.out_free   = !out_valid_q || out_ready_i;

endmodule

@@ rtl/core/unison_detuned_oscillator.sv @@
// Top level of the unison detuned oscillator: sequencer plus datapath.
//
// Input channel (in_valid_i/in_ready_o) carries op_i and time_step_i. An
// advance word (op 0) moves every active voice phase by its increment times
// time_step_i (Q8.8) and gives no result. A sample word (op 1) gives one
// stereo word on the output channel (out_valid_o/out_ready_i).
// Settings are written through cfg_we_i/cfg_idx_i/cfg_data_i while idle.
// Items run one at a time; in_ready_o is high only between items.
// Each voice costs one or two passes of the shared serial divider, so the
// divider sets the rate.
// A finished sample sits in an output register, so the next word is taken
// while the receiver stalls; a second sample waits in its last step until
// that register frees.
// Reset clears the settings to their defaults and all phases to zero; no
// clearing pass is needed.
module unison_detuned_oscillator #(
  parameter int unsigned MAX_VOICES       = 16,
  parameter int unsigned SAMPLE_RATE_HZ   = 48000,
  parameter int unsigned SINE_TABLE_DEPTH = 1024
) (
  input  logic                              clk_i,
  input  logic                              rst_ni,
  input  logic                              in_valid_i,
  output logic                              in_ready_o,
  input  logic                              op_i,
  input  logic [15:0]                       time_step_i,
  input  logic                              cfg_we_i,
  input  logic [udo_pkg::CFG_IDX_W-1:0]     cfg_idx_i,
  input  logic [udo_pkg::CFG_DATA_W-1:0]    cfg_data_i,
  output logic                              out_valid_o,
  input  logic                              out_ready_i,
  output logic signed [31:0]                left_sample_o,
  output logic signed [31:0]                right_sample_o
);

  udo_pkg::cmd_t    cmd;
  udo_pkg::status_t status;

  udo_ctrl u_ctrl (
    .clk_i      (clk_i),
    .rst_ni     (rst_ni),
    .in_valid_i (in_valid_i),
    .in_ready_o (in_ready_o),
    .status_i   (status),
    .cmd_o      (cmd)
  );

  udo_dp #(
    .MAX_VOICES       (MAX_VOICES),
    .SAMPLE_RATE_HZ   (SAMPLE_RATE_HZ),
    .SINE_TABLE_DEPTH (SINE_TABLE_DEPTH)
  ) u_dp (
    .clk_i          (clk_i),
    .rst_ni         (rst_ni),
    .cmd_i          (cmd),
    .status_o       (status),
    .cfg_we_i       (cfg_we_i),
    .cfg_idx_i      (cfg_idx_i),
    .cfg_data_i     (cfg_data_i),
    .op_i           (op_i),
    .time_step_i    (time_step_i),
    .out_ready_i    (out_ready_i),
    .out_valid_o    (out_valid_o),
    .left_sample_o  (left_sample_o),
    .right_sample_o (right_sample_o)
  );

endmodule
